// ----- hw/rtl/lpl_pkg.sv -----
// ----------------------------------------------------------------------------
// Lookahead peak limiter package
// Shared constants, register indexes, sequencer states and divider types.
// ----------------------------------------------------------------------------
package lpl_pkg;

  // Default ring depth per channel
  localparam int unsigned RING_DEPTH_DEF = 512;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_CHANNELS  = 3'd1;
  localparam logic [2:0] CFG_LOOKAHEAD = 3'd2;
  localparam logic [2:0] CFG_RELEASE   = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD = 3'd4;

  // Configuration reset values
  localparam logic        ENABLE_RST    = 1'b1;
  localparam logic [1:0]  CHANNELS_RST  = 2'd2;
  localparam logic [9:0]  LOOKAHEAD_RST = 10'd48;
  localparam logic [15:0] RELEASE_RST   = 16'd65400;
  localparam logic [15:0] THRESHOLD_RST = 16'd32768;

  // Unity gain in Q1.16
  localparam logic [16:0] UNITY_GAIN = 17'h10000;

  // Quotient bits produced by the divider, one per cycle
  localparam int unsigned DIV_STEPS = 16;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_SCAN,
    ST_TAIL,
    ST_REL,
    ST_REL_ADD,
    ST_GAIN,
    ST_DIV,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/lpl_div.sv -----
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider for (num << 16) / den with num < den; one quotient bit
// per cycle, done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module lpl_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpl_pkg::div_req_t req_i,
  output lpl_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [15:0] quot_q, quot_d;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        q_bit;

  // One shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, den_q};
    q_bit   = (rem_sh >= {1'b0, den_q});

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d  = q_bit ? rem_sub[15:0] : rem_sh[15:0];
      quot_d = {quot_q[14:0], q_bit};
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'(lpl_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial quotient
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- hw/rtl/lookahead_peak_limiter.sv -----
// ----------------------------------------------------------------------------
// Lookahead peak limiter
// Mono or stereo Q1.15 limiter with peak window scan, instant attack, exponential
// release and a divided gain applied to the oldest sample of the window.
// ----------------------------------------------------------------------------
// One request is worked on at a time. With the limiter enabled the effective
// window is read back one ring entry per cycle through the single read port
// of each channel ring, and when the envelope is above the threshold the gain
// divider produces one quotient bit per cycle. A disabled limiter passes a
// request on unscaled, with unity gain. After reset the rings are swept to
// zero, one entry a cycle, before the first request is taken; configuration
// writes are taken at all times.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter #(
  parameter int unsigned RING_DEPTH = lpl_pkg::RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // sample requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_left_i,
  input  logic signed [15:0] sample_right_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_right_o,
  output logic [16:0]        gain_out_o
);

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned LW = (CW > 10) ? CW : 10;

  // Magnitude of a Q1.15 sample; -32768 gives 32768
  function automatic logic [15:0] mag16(input logic [15:0] s);
    logic [15:0] neg;
    neg = ~s + 16'd1;
    return s[15] ? neg : s;
  endfunction

  // Configuration registers
  logic        enable_q;
  logic [1:0]  channels_q;
  logic [9:0]  lookahead_q;
  logic [15:0] release_q;
  logic [15:0] threshold_q;

  // Sequencer and datapath state
  lpl_pkg::state_e state_q, state_d;
  logic [IW-1:0]   clr_q;
  logic [IW-1:0]   widx_q;
  logic [IW-1:0]   scan_addr_q;
  logic [CW-1:0]   issue_q;
  logic            rd_vld_q, rd_last_q;
  logic            stereo_q;
  logic [15:0]     peak_q;
  logic [15:0]     env_q;
  logic [16:0]     gain_q;
  logic [15:0]     hold_left_q, hold_right_q;
  logic [15:0]     old_left_q, old_right_q;
  logic [15:0]     res_left_q;
  logic signed [34:0] mul_q;
  logic            out_valid_q;
  logic [15:0]     out_left_q, out_right_q;
  logic [16:0]     gain_out_q;

  // Ring memories
  logic [15:0] ring_left  [RING_DEPTH];
  logic [15:0] ring_right [RING_DEPTH];
  logic [15:0] rd_left_q, rd_right_q;

  // Control decode
  logic            in_acc;
  logic            out_free;
  logic [LW-1:0]   lk_ext;
  logic [CW-1:0]   len_c;
  logic            last_issue;
  logic            ring_we_l, ring_we_r;
  logic [IW-1:0]   ring_waddr;
  logic [15:0]     ring_wdata_l, ring_wdata_r;
  logic            mul_en;
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic [15:0]     mag_l, mag_r, peak_n;
  lpl_pkg::div_req_t div_req;
  lpl_pkg::div_rsp_t div_rsp;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Effective window length: zero reads as one, saturates at the ring depth
  always_comb begin
    lk_ext = LW'(lookahead_q);
    if (lookahead_q == '0) begin
      len_c = CW'(1);
    end else if (lk_ext > LW'(RING_DEPTH)) begin
      len_c = CW'(RING_DEPTH);
    end else begin
      len_c = CW'(lk_ext);
    end
  end

  assign last_issue = (issue_q == len_c - CW'(1));

  // Sequencer: next state and control outputs
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = threshold_q;
    div_req.den   = env_q;
    case (state_q)
      lpl_pkg::ST_CLEAR: begin
        if (clr_q == IW'(RING_DEPTH - 1)) begin
          state_d = lpl_pkg::ST_IDLE;
        end
      end
      lpl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = enable_q ? lpl_pkg::ST_SCAN : lpl_pkg::ST_PASS;
        end
      end
      lpl_pkg::ST_PASS: begin
        if (out_free) begin
          state_d = lpl_pkg::ST_IDLE;
        end
      end
      lpl_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_d = lpl_pkg::ST_TAIL;
        end
      end
      lpl_pkg::ST_TAIL: begin
        state_d = lpl_pkg::ST_REL;
      end
      lpl_pkg::ST_REL: begin
        if (peak_q > env_q) begin
          state_d = lpl_pkg::ST_GAIN;
        end else begin
          mul_en  = 1'b1;
          mul_a   = signed'({1'b0, env_q - peak_q});
          mul_b   = signed'({2'b00, release_q});
          state_d = lpl_pkg::ST_REL_ADD;
        end
      end
      lpl_pkg::ST_REL_ADD: begin
        state_d = lpl_pkg::ST_GAIN;
      end
      lpl_pkg::ST_GAIN: begin
        if (env_q > threshold_q) begin
          div_req.start = 1'b1;
          state_d       = lpl_pkg::ST_DIV;
        end else begin
          state_d = lpl_pkg::ST_MUL_L;
        end
      end
      lpl_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = lpl_pkg::ST_MUL_L;
        end
      end
      lpl_pkg::ST_MUL_L: begin
        mul_en  = 1'b1;
        mul_a   = signed'({old_left_q[15], old_left_q});
        mul_b   = signed'({1'b0, gain_q});
        state_d = lpl_pkg::ST_MUL_R;
      end
      lpl_pkg::ST_MUL_R: begin
        mul_en  = 1'b1;
        mul_a   = signed'({old_right_q[15], old_right_q});
        mul_b   = signed'({1'b0, gain_q});
        state_d = lpl_pkg::ST_DONE;
      end
      lpl_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpl_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= lpl_pkg::ENABLE_RST;
      channels_q  <= lpl_pkg::CHANNELS_RST;
      lookahead_q <= lpl_pkg::LOOKAHEAD_RST;
      release_q   <= lpl_pkg::RELEASE_RST;
      threshold_q <= lpl_pkg::THRESHOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lpl_pkg::CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        lpl_pkg::CFG_CHANNELS:  channels_q  <= cfg_data_i[1:0];
        lpl_pkg::CFG_LOOKAHEAD: lookahead_q <= cfg_data_i[9:0];
        lpl_pkg::CFG_RELEASE:   release_q   <= cfg_data_i;
        lpl_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring write port: clearing sweep, or the new sample pair
  always_comb begin
    if (state_q == lpl_pkg::ST_CLEAR) begin
      ring_we_l    = 1'b1;
      ring_we_r    = 1'b1;
      ring_waddr   = clr_q;
      ring_wdata_l = '0;
      ring_wdata_r = '0;
    end else begin
      ring_we_l    = in_acc && enable_q;
      ring_we_r    = in_acc && enable_q && channels_q[1];
      ring_waddr   = widx_q;
      ring_wdata_l = sample_left_i;
      ring_wdata_r = sample_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we_l) begin
      ring_left[ring_waddr] <= ring_wdata_l;
    end
    if (ring_we_r) begin
      ring_right[ring_waddr] <= ring_wdata_r;
    end
    rd_left_q  <= ring_left[scan_addr_q];
    rd_right_q <= ring_right[scan_addr_q];
  end

  // Window peak of the data read back this cycle
  always_comb begin
    mag_l  = mag16(rd_left_q);
    mag_r  = mag16(rd_right_q);
    peak_n = peak_q;
    if (mag_l > peak_n) begin
      peak_n = mag_l;
    end
    if (stereo_q && (mag_r > peak_n)) begin
      peak_n = mag_r;
    end
  end

  // Sequencer counters, envelope and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      widx_q      <= '0;
      scan_addr_q <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q  <= (state_q == lpl_pkg::ST_SCAN);
      rd_last_q <= (state_q == lpl_pkg::ST_SCAN) && last_issue;

      if (state_q == lpl_pkg::ST_CLEAR) begin
        clr_q <= clr_q + IW'(1);
      end

      // scan walks backward from the newest entry
      if (in_acc) begin
        scan_addr_q <= widx_q;
        issue_q     <= '0;
      end else if (state_q == lpl_pkg::ST_SCAN) begin
        scan_addr_q <= (scan_addr_q == '0) ? IW'(RING_DEPTH - 1) : scan_addr_q - IW'(1);
        issue_q     <= issue_q + CW'(1);
      end

      // envelope: instant attack, release through the multiplier
      if (state_q == lpl_pkg::ST_REL && peak_q > env_q) begin
        env_q <= peak_q;
      end else if (state_q == lpl_pkg::ST_REL_ADD) begin
        env_q <= peak_q + mul_q[31:16];
      end

      if (state_q == lpl_pkg::ST_DONE && out_free) begin
        widx_q <= (widx_q == IW'(RING_DEPTH - 1)) ? '0 : widx_q + IW'(1);
      end

      if ((state_q == lpl_pkg::ST_DONE || state_q == lpl_pkg::ST_PASS) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stereo_q     <= channels_q[1];
      hold_left_q  <= sample_left_i;
      hold_right_q <= sample_right_i;
      peak_q       <= '0;
    end else if (rd_vld_q) begin
      peak_q <= peak_n;
    end

    // oldest entry of the window is the last one read
    if (rd_last_q) begin
      old_left_q  <= rd_left_q;
      old_right_q <= rd_right_q;
    end

    // shared multiplier
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end

    if (state_q == lpl_pkg::ST_GAIN && !(env_q > threshold_q)) begin
      gain_q <= lpl_pkg::UNITY_GAIN;
    end else if (state_q == lpl_pkg::ST_DIV && div_rsp.done) begin
      gain_q <= {1'b0, div_rsp.quot};
    end

    if (state_q == lpl_pkg::ST_MUL_R) begin
      res_left_q <= mul_q[31:16];
    end

    // result register
    if (state_q == lpl_pkg::ST_DONE && out_free) begin
      out_left_q  <= res_left_q;
      out_right_q <= stereo_q ? mul_q[31:16] : '0;
      gain_out_q  <= gain_q;
    end else if (state_q == lpl_pkg::ST_PASS && out_free) begin
      out_left_q  <= hold_left_q;
      out_right_q <= stereo_q ? hold_right_q : '0;
      gain_out_q  <= lpl_pkg::UNITY_GAIN;
    end
  end

  // Gain divider
  lpl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_left_o  = signed'(out_left_q);
  assign out_right_o = signed'(out_right_q);
  assign gain_out_o  = gain_out_q;

endmodule

// ----- hw/rtl/lpl_checker.sv -----
// ----------------------------------------------------------------------------
// Lookahead peak limiter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lpl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] out_left_o,
  input logic signed [15:0] out_right_o,
  input logic [16:0]        gain_out_o
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a pending result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_left_o) && $stable(out_right_o) && $stable(gain_out_o))
    else $error("result payload changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  // gain never above unity
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_out_o <= 17'h10000))
    else $error("gain above unity");

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_left_o  (out_left_o),
  .out_right_o (out_right_o),
  .gain_out_o  (gain_out_o)
);

// ----- tb/lookahead_peak_limiter_tb.sv -----
// ----------------------------------------------------------------------------
// Lookahead peak limiter testbench
// Sends stereo sample requests through the limiter under a series of register
// settings and compares every result against a cycle-free model of the ring
// scan, envelope, gain divide and output scaling held in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lookahead_peak_limiter_tb;

  localparam int unsigned RING         = lpl_pkg::RING_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET  = 540;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned END_LIMIT    = 100000;

  // One limiter result
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [16:0]        gain;
  } result_t;

  // Limiter model plus queue of pending results
  class limiter_scoreboard;
    bit          enable;
    bit [1:0]    channels;
    bit [9:0]    lookahead;
    bit [15:0]   rel_coef;
    bit [15:0]   thr;
    bit [15:0]   ring_l [RING];
    bit [15:0]   ring_r [RING];
    int unsigned wr_pos;
    int unsigned envelope;
    result_t     pending_q [$];
    int unsigned accepted, checked, reduced, mismatches;

    function new();
      enable    = lpl_pkg::ENABLE_RST;
      channels  = lpl_pkg::CHANNELS_RST;
      lookahead = lpl_pkg::LOOKAHEAD_RST;
      rel_coef  = lpl_pkg::RELEASE_RST;
      thr       = lpl_pkg::THRESHOLD_RST;
      foreach (ring_l[i]) begin
        ring_l[i] = '0;
        ring_r[i] = '0;
      end
      wr_pos   = 0;
      envelope = 0;
    endfunction

    function void note_config(logic [2:0] idx, logic [15:0] data);
      case (idx)
        lpl_pkg::CFG_ENABLE:    enable    = data[0];
        lpl_pkg::CFG_CHANNELS:  channels  = data[1:0];
        lpl_pkg::CFG_LOOKAHEAD: lookahead = data[9:0];
        lpl_pkg::CFG_RELEASE:   rel_coef  = data;
        lpl_pkg::CFG_THRESHOLD: thr       = data;
        default: ;
      endcase
    endfunction

    function int unsigned mag(bit [15:0] raw);
      return raw[15] ? 32'(17'h10000 - raw) : 32'(raw);
    endfunction

    // floor(sample * gain / 2^16)
    function logic [15:0] scaled(bit [15:0] raw, longint unsigned gain);
      longint prod;
      prod = longint'($signed(raw)) * longint'(gain);
      return 16'(prod >>> 16);
    endfunction

    function void note_input(logic [15:0] left, logic [15:0] right);
      result_t         res;
      bit              stereo;
      int unsigned     span, peak, pos, tap;
      longint unsigned gain;
      stereo = (channels >= 2);
      accepted++;
      // bypass leaves all state alone
      if (!enable) begin
        res.left  = left;
        res.right = stereo ? right : '0;
        res.gain  = lpl_pkg::UNITY_GAIN;
        pending_q.push_back(res);
        return;
      end
      span = (lookahead == 0) ? 1 : (lookahead > RING) ? RING : lookahead;
      ring_l[wr_pos] = left;
      if (stereo) ring_r[wr_pos] = right;
      // peak over the newest span entries
      peak = 0;
      for (int d = 0; d < span; d++) begin
        pos = (wr_pos + RING - d) % RING;
        if (mag(ring_l[pos]) > peak) peak = mag(ring_l[pos]);
        if (stereo && mag(ring_r[pos]) > peak) peak = mag(ring_r[pos]);
      end
      // instant attack, exponential release
      if (peak > envelope) envelope = peak;
      else envelope = peak + int'((longint'(envelope - peak) * longint'(rel_coef)) >> 16);
      envelope &= 32'hFFFF;
      gain = (envelope > thr) ? ((longint'(thr) << 16) / envelope) : 65536;
      tap = (wr_pos + RING - (span - 1)) % RING;
      res.left  = scaled(ring_l[tap], gain);
      res.right = stereo ? scaled(ring_r[tap], gain) : '0;
      res.gain  = gain[16:0];
      pending_q.push_back(res);
      wr_pos = (wr_pos + 1) % RING;
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s, result %0d: expected %0d, got %0d",
                 what, checked, want, got);
    endfunction

    function void check_result(logic signed [15:0] left, logic signed [15:0] right,
                               logic [16:0] gain);
      result_t want;
      if (pending_q.size() == 0) begin
        flag("unrequested result", 0, gain);
        return;
      end
      want = pending_q.pop_front();
      if (left !== want.left) flag("out_left", want.left, left);
      if (right !== want.right) flag("out_right", want.right, right);
      if (gain !== want.gain) flag("gain_out", want.gain, gain);
      if (want.gain != lpl_pkg::UNITY_GAIN) reduced++;
      checked++;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] sample_left_i;
  logic signed [15:0] sample_right_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] out_left_o;
  logic signed [15:0] out_right_o;
  logic [16:0]        gain_out_o;

  limiter_scoreboard sb;
  bit                src_steady;
  bit                sink_free;
  int unsigned       settings_used;

  lookahead_peak_limiter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .gain_out_o     (gain_out_o)
  );

  // 100 MHz clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_left_o, out_right_o, gain_out_o);
  end

  // Receiver: ready stretches broken by short or long stalls, unless sink_free is set
  initial begin : sink_pattern
    int unsigned run, hold;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      run  = $urandom_range(1, 40);
      hold = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!sink_free && hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold - 1) @(posedge clk_i);
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    #20_000_000;
    $display("[lookahead_peak_limiter] ERROR");
    $finish;
  end

  // Register write; valid stays up for back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  task automatic program_settings(bit en, bit [1:0] ch, bit [9:0] len,
                                  bit [15:0] rel, bit [15:0] thr);
    write_reg(lpl_pkg::CFG_ENABLE, {15'd0, en});
    write_reg(lpl_pkg::CFG_CHANNELS, {14'd0, ch});
    write_reg(lpl_pkg::CFG_LOOKAHEAD, {6'd0, len});
    write_reg(lpl_pkg::CFG_RELEASE, rel);
    write_reg(lpl_pkg::CFG_THRESHOLD, thr);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Sample request; valid is left high for a following request
  task automatic send_pair(logic [15:0] left, logic [15:0] right);
    in_valid_i     <= 1'b1;
    sample_left_i  <= left;
    sample_right_i <= right;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(left, right);
  endtask

  // Drop valid and let every pending result come back
  task automatic finish_batch();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample(int unsigned amp);
    int v;
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom);
      default: begin
        v = int'($urandom_range(0, 2 * amp)) - int'(amp);
        return 16'(v);
      end
    endcase
  endfunction

  // Program material: bursts of quiet, medium and loud samples with gaps unless src_steady is set
  task automatic play_passage(int unsigned count);
    int unsigned burst_left, gap, amp;
    burst_left = 0;
    amp = 32767;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       amp = $urandom_range(0, 300);
          1:       amp = $urandom_range(301, 16000);
          default: amp = 32767;
        endcase
        if (src_steady) gap = 0;
        else if ($urandom_range(0, 4) == 0) gap = $urandom_range(30, 80);
        else gap = $urandom_range(0, 10);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      send_pair(pick_sample(amp), pick_sample(amp));
    end
    finish_batch();
  endtask

  initial begin : stimulus
    bit          en;
    bit [1:0]    ch;
    bit [9:0]    len;
    bit [15:0]   rel, thr;
    int unsigned guard;
    sb = new();
    settings_used = 0;
    src_steady = 1'b1;
    sink_free  = 1'b0;
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= lpl_pkg::CFG_ENABLE;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    sample_left_i  <= '0;
    sample_right_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, full scale both polarities
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h0000, 16'h0000);
    finish_batch();

    // short window, instant release, half-scale ceiling
    program_settings(1'b1, 2'd2, 10'd4, 16'd0, 16'd16384);
    send_pair(16'h7FFF, 16'hFFFF);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h0001, 16'h8000);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hFFFF, 16'h0001);
    send_pair(16'h4000, 16'hC000);
    repeat (4) send_pair(16'h0000, 16'h0000);
    finish_batch();

    // unused register indexes, then bypass
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'hFFFF);
    program_settings(1'b0, 2'd3, 10'd1023, 16'hFFFF, 16'd0);
    send_pair(16'd123, 16'hFE38);
    send_pair(16'h8000, 16'h7FFF);
    finish_batch();

    // mono, zero window length, ceiling above full scale
    program_settings(1'b1, 2'd1, 10'd0, 16'hFFFF, 16'hFFFF);
    send_pair(16'h8000, 16'd1234);
    send_pair(16'h7FFF, 16'hFFFF);
    finish_batch();

    // mono via zero count, longest window, zero ceiling
    program_settings(1'b1, 2'd0, 10'd1023, 16'd32768, 16'd0);
    send_pair(16'h8000, 16'd5);
    send_pair(16'd7, 16'd7);
    finish_batch();

    // stereo via count three, slowest release
    program_settings(1'b1, 2'd3, 10'd1, 16'hFFFF, 16'd8192);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'd100, 16'hFF9C);
    finish_batch();

    // random settings with program material
    while (sb.accepted < ITEM_TARGET) begin
      en = ($urandom_range(0, 7) != 0);
      ch = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0:       len = 10'd0;
        1:       len = 10'd1023;
        2:       len = 10'd512;
        3:       len = 10'($urandom_range(65, 1023));
        default: len = 10'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       rel = 16'd0;
        1:       rel = 16'hFFFF;
        2, 3:    rel = 16'($urandom_range(60000, 65535));
        default: rel = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       thr = 16'd0;
        1:       thr = 16'hFFFF;
        2:       thr = 16'd32768;
        default: thr = 16'($urandom_range(0, 32767));
      endcase
      src_steady = ($urandom_range(0, 3) == 0);
      sink_free  = ($urandom_range(0, 3) == 0);
      program_settings(en, ch, len, rel, thr);
      play_passage((len > 64 || len == 0) ? $urandom_range(4, 10) : $urandom_range(15, 45));
    end

    // final drain with a cap
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < END_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d sample requests under %0d limiter settings, %0d results checked",
             sb.accepted, settings_used, sb.checked);
    $display("%0d results under gain reduction, %0d mismatches, %0d results missing",
             sb.reduced, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[lookahead_peak_limiter] OK");
    else
      $display("[lookahead_peak_limiter] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lpl_pkg.sv
hw/rtl/lpl_div.sv
hw/rtl/lookahead_peak_limiter.sv
hw/rtl/lpl_checker.sv
tb/lookahead_peak_limiter_tb.sv
